// ----- design/max_pool_2d_argmax_defines.svh -----
// assertion macros for the max pooling checker
// expects clk and rst_n in the scope of use
`ifndef MAX_POOL_2D_ARGMAX_DEFINES_SVH
`define MAX_POOL_2D_ARGMAX_DEFINES_SVH

// same-cycle implication
`define MPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mpa_pkg.sv -----
// shared types and constants for the max pooling block
// no dependencies
`timescale 1ns / 1ps

package mpa_pkg;

    localparam int MAX_HEIGHT_DEF  = 64;
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_WINDOW_DEF  = 16;

    localparam int ROW_BITS   = 6;
    localparam int COL_BITS   = 6;
    localparam int PLANE_BITS = 12;
    localparam int IDX_BITS   = 25;

    localparam int HEIGHT_BITS = 7;
    localparam int STRIDE_BITS = 5;
    localparam int WINDOW_BITS = 5;
    localparam int PAD_BITS    = 4;

    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [HEIGHT_BITS-1:0] IN_HEIGHT_RST = 7'd1;
    localparam logic [HEIGHT_BITS-1:0] IN_WIDTH_RST  = 7'd1;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RST    = 5'd1;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RST    = 5'd2;
    localparam logic [PAD_BITS-1:0]    PAD_RST       = 4'd0;

    typedef enum logic [CFG_ADDR_BITS-3:0] {
        CFG_IN_HEIGHT   = 3'd0,
        CFG_IN_WIDTH    = 3'd1,
        CFG_STRIDE_ROWS = 3'd2,
        CFG_STRIDE_COLS = 3'd3,
        CFG_WINDOW_ROWS = 3'd4,
        CFG_WINDOW_COLS = 3'd5,
        CFG_PAD_ROWS    = 3'd6,
        CFG_PAD_COLS    = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// ----- design/mpa_req_if.sv -----
// request channel: load or query beat
// depends on mpa_pkg
`timescale 1ns / 1ps

interface mpa_req_if #(
    parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [mpa_pkg::ROW_BITS-1:0]    row;
    logic [mpa_pkg::COL_BITS-1:0]    col;
    logic signed [SAMPLE_BITS-1:0]   sample;
    logic [mpa_pkg::PLANE_BITS-1:0]  plane;

    modport source (output valid, req_type, row, col, sample, plane, input ready);
    modport sink (input valid, req_type, row, col, sample, plane, output ready);
endinterface

// ----- design/mpa_res_if.sv -----
// result channel: pooled maximum and its flat index
// depends on mpa_pkg
`timescale 1ns / 1ps

interface mpa_res_if #(
    parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_BITS-1:0]       max_value;
    logic signed [mpa_pkg::IDX_BITS-1:0] max_index;
    logic                                window_empty;

    modport source (output valid, max_value, max_index, window_empty, input ready);
    modport sink (input valid, max_value, max_index, window_empty, output ready);
endinterface

// ----- design/mpa_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module mpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/max_pool_2d_argmax.sv -----
// channel  | dir | handshake     | payload
// req      | in  | valid / ready | req_type, row, col, sample, plane
// res      | out | valid / ready | max_value, max_index, window_empty
// apb      | in  | psel/penable  | paddr, pwdata, prdata
//
// a load writes the plane store (row and col in range); a query reads it once per window
// position, then drain and finish (index formed) states; an empty window goes to finish
// the single read port of the plane store and the one compare unit set the rate
// reset clears control and configuration; the plane store is not cleared
// req.ready is low while a query is in work or its result waits for the output register
// the output register holds a result under stall while the next beat is taken
// depends on mpa_pkg, mpa_req_if, mpa_res_if, mpa_ram
`timescale 1ns / 1ps

module max_pool_2d_argmax #(
    parameter int MAX_HEIGHT  = mpa_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH   = mpa_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW  = mpa_pkg::MAX_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    mpa_req_if.sink                            req,
    mpa_res_if.source                          res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mpa_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [mpa_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [mpa_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int IW    = mpa_pkg::IDX_BITS;
    localparam int EHW   = ($clog2(MAX_HEIGHT + 1) > mpa_pkg::HEIGHT_BITS) ?
                           $clog2(MAX_HEIGHT + 1) : mpa_pkg::HEIGHT_BITS;
    localparam int EWW   = ($clog2(MAX_WIDTH + 1) > mpa_pkg::HEIGHT_BITS) ?
                           $clog2(MAX_WIDTH + 1) : mpa_pkg::HEIGHT_BITS;
    localparam int WW    = ($clog2(MAX_WINDOW + 1) > mpa_pkg::WINDOW_BITS) ?
                           $clog2(MAX_WINDOW + 1) : mpa_pkg::WINDOW_BITS;
    localparam int CW    = mpa_pkg::ROW_BITS + mpa_pkg::STRIDE_BITS + WW + 2;

    // configuration
    logic [mpa_pkg::HEIGHT_BITS-1:0] cfg_in_height_reg;
    logic [mpa_pkg::HEIGHT_BITS-1:0] cfg_in_width_reg;
    logic [mpa_pkg::STRIDE_BITS-1:0] cfg_stride_rows_reg;
    logic [mpa_pkg::STRIDE_BITS-1:0] cfg_stride_cols_reg;
    logic [mpa_pkg::WINDOW_BITS-1:0] cfg_window_rows_reg;
    logic [mpa_pkg::WINDOW_BITS-1:0] cfg_window_cols_reg;
    logic [mpa_pkg::PAD_BITS-1:0]    cfg_pad_rows_reg;
    logic [mpa_pkg::PAD_BITS-1:0]    cfg_pad_cols_reg;
    logic                            cfg_we;
    mpa_pkg::cfg_reg_t               cfg_sel;

    // sequencer
    mpa_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cur_r_reg, cur_r_next;
    logic [CW-1:0]   cur_c_reg, cur_c_next;
    logic [CW-1:0]   c0_reg, c0_next;
    logic [WW-1:0]   cnt_r_reg, cnt_r_next;
    logic [WW-1:0]   cnt_c_reg, cnt_c_next;
    logic [IW-1:0]   base_reg, base_next;
    logic            rd_valid_reg, rd_valid_next;
    logic [RW-1:0]   rd_r_reg, rd_r_next;
    logic [CLW-1:0]  rd_c_reg, rd_c_next;
    logic            found_reg, found_next;
    logic [SAMPLE_BITS-1:0] best_value_reg, best_value_next;
    logic [RW-1:0]   best_r_reg, best_r_next;
    logic [CLW-1:0]  best_c_reg, best_c_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_value_reg, out_value_next;
    logic [IW-1:0]          out_index_reg, out_index_next;
    logic                   out_empty_reg, out_empty_next;

    logic [EHW-1:0]         eh;
    logic [EWW-1:0]         ew;
    logic [WW-1:0]          wr;
    logic [WW-1:0]          wc;
    logic                   in_accept;
    logic                   in_plane;
    logic                   out_free;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_q;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_sel = mpa_pkg::cfg_reg_t'(paddr[mpa_pkg::CFG_ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_in_height_reg   <= mpa_pkg::IN_HEIGHT_RST;
            cfg_in_width_reg    <= mpa_pkg::IN_WIDTH_RST;
            cfg_stride_rows_reg <= mpa_pkg::STRIDE_RST;
            cfg_stride_cols_reg <= mpa_pkg::STRIDE_RST;
            cfg_window_rows_reg <= mpa_pkg::WINDOW_RST;
            cfg_window_cols_reg <= mpa_pkg::WINDOW_RST;
            cfg_pad_rows_reg    <= mpa_pkg::PAD_RST;
            cfg_pad_cols_reg    <= mpa_pkg::PAD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                mpa_pkg::CFG_IN_HEIGHT:
                    cfg_in_height_reg <= pwdata[mpa_pkg::HEIGHT_BITS-1:0];
                mpa_pkg::CFG_IN_WIDTH:
                    cfg_in_width_reg <= pwdata[mpa_pkg::HEIGHT_BITS-1:0];
                mpa_pkg::CFG_STRIDE_ROWS:
                    cfg_stride_rows_reg <= pwdata[mpa_pkg::STRIDE_BITS-1:0];
                mpa_pkg::CFG_STRIDE_COLS:
                    cfg_stride_cols_reg <= pwdata[mpa_pkg::STRIDE_BITS-1:0];
                mpa_pkg::CFG_WINDOW_ROWS:
                    cfg_window_rows_reg <= pwdata[mpa_pkg::WINDOW_BITS-1:0];
                mpa_pkg::CFG_WINDOW_COLS:
                    cfg_window_cols_reg <= pwdata[mpa_pkg::WINDOW_BITS-1:0];
                mpa_pkg::CFG_PAD_ROWS:
                    cfg_pad_rows_reg <= pwdata[mpa_pkg::PAD_BITS-1:0];
                mpa_pkg::CFG_PAD_COLS:
                    cfg_pad_cols_reg <= pwdata[mpa_pkg::PAD_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            mpa_pkg::CFG_IN_HEIGHT:   prdata = mpa_pkg::CFG_DATA_BITS'(cfg_in_height_reg);
            mpa_pkg::CFG_IN_WIDTH:    prdata = mpa_pkg::CFG_DATA_BITS'(cfg_in_width_reg);
            mpa_pkg::CFG_STRIDE_ROWS: prdata = mpa_pkg::CFG_DATA_BITS'(cfg_stride_rows_reg);
            mpa_pkg::CFG_STRIDE_COLS: prdata = mpa_pkg::CFG_DATA_BITS'(cfg_stride_cols_reg);
            mpa_pkg::CFG_WINDOW_ROWS: prdata = mpa_pkg::CFG_DATA_BITS'(cfg_window_rows_reg);
            mpa_pkg::CFG_WINDOW_COLS: prdata = mpa_pkg::CFG_DATA_BITS'(cfg_window_cols_reg);
            mpa_pkg::CFG_PAD_ROWS:    prdata = mpa_pkg::CFG_DATA_BITS'(cfg_pad_rows_reg);
            mpa_pkg::CFG_PAD_COLS:    prdata = mpa_pkg::CFG_DATA_BITS'(cfg_pad_cols_reg);
            default:                  prdata = '0;
        endcase
    end

    // effective plane and window sizes
    always_comb
    begin
        eh = (EHW'(cfg_in_height_reg) > EHW'(MAX_HEIGHT)) ?
             EHW'(MAX_HEIGHT) : EHW'(cfg_in_height_reg);
        ew = (EWW'(cfg_in_width_reg) > EWW'(MAX_WIDTH)) ?
             EWW'(MAX_WIDTH) : EWW'(cfg_in_width_reg);
        wr = (WW'(cfg_window_rows_reg) > WW'(MAX_WINDOW)) ?
             WW'(MAX_WINDOW) : WW'(cfg_window_rows_reg);
        wc = (WW'(cfg_window_cols_reg) > WW'(MAX_WINDOW)) ?
             WW'(MAX_WINDOW) : WW'(cfg_window_cols_reg);
    end

    assign req.ready = (state_reg == mpa_pkg::ST_IDLE);
    assign in_accept = req.valid && req.ready;
    assign out_free  = !out_valid_reg || res.ready;

    // plane store
    assign ram_we    = in_accept && (req.req_type == mpa_pkg::REQ_LOAD) &&
                       (int'(req.row) < MAX_HEIGHT) && (int'(req.col) < MAX_WIDTH);
    assign ram_waddr = AW'(AW'(req.row) * AW'(MAX_WIDTH) + AW'(req.col));
    assign ram_raddr = AW'(AW'(cur_r_reg[RW-1:0]) * AW'(MAX_WIDTH) +
                           AW'(cur_c_reg[CLW-1:0]));

    assign in_plane = !cur_r_reg[CW-1] && (cur_r_reg < CW'(eh)) &&
                      !cur_c_reg[CW-1] && (cur_c_reg < CW'(ew));

    mpa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_mpa_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.sample),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        cur_r_next      = cur_r_reg;
        cur_c_next      = cur_c_reg;
        c0_next         = c0_reg;
        cnt_r_next      = cnt_r_reg;
        cnt_c_next      = cnt_c_reg;
        base_next       = base_reg;
        rd_valid_next   = 1'b0;
        rd_r_next       = cur_r_reg[RW-1:0];
        rd_c_next       = cur_c_reg[CLW-1:0];
        found_next      = found_reg;
        best_value_next = best_value_reg;
        best_r_next     = best_r_reg;
        best_c_next     = best_c_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_empty_next  = out_empty_reg;

        // shared compare unit, one window sample a cycle
        if (rd_valid_reg && (!found_reg ||
            ($signed(ram_q) > $signed(best_value_reg))))
        begin
            found_next      = 1'b1;
            best_value_next = ram_q;
            best_r_next     = rd_r_reg;
            best_c_next     = rd_c_reg;
        end

        case (state_reg)
            mpa_pkg::ST_IDLE:
            begin
                if (in_accept && (req.req_type == mpa_pkg::REQ_QUERY))
                begin
                    cur_r_next = CW'(CW'(req.row) * CW'(cfg_stride_rows_reg)) -
                                 CW'(cfg_pad_rows_reg);
                    c0_next    = CW'(CW'(req.col) * CW'(cfg_stride_cols_reg)) -
                                 CW'(cfg_pad_cols_reg);
                    cur_c_next = CW'(CW'(req.col) * CW'(cfg_stride_cols_reg)) -
                                 CW'(cfg_pad_cols_reg);
                    base_next  = IW'(IW'(req.plane) * IW'(eh));
                    cnt_r_next = '0;
                    cnt_c_next = '0;
                    found_next = 1'b0;
                    if ((wr == '0) || (wc == '0))
                    begin
                        state_next = mpa_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = mpa_pkg::ST_SCAN;
                    end
                end
            end
            mpa_pkg::ST_SCAN:
            begin
                rd_valid_next = in_plane;
                if (cnt_c_reg == wc - WW'(1))
                begin
                    cnt_c_next = '0;
                    cur_c_next = c0_reg;
                    cnt_r_next = cnt_r_reg + WW'(1);
                    cur_r_next = cur_r_reg + CW'(1);
                    if (cnt_r_reg == wr - WW'(1))
                    begin
                        state_next = mpa_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    cnt_c_next = cnt_c_reg + WW'(1);
                    cur_c_next = cur_c_reg + CW'(1);
                end
            end
            mpa_pkg::ST_DRAIN:
            begin
                state_next = mpa_pkg::ST_FINISH;
            end
            mpa_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_empty_next = !found_reg;
                    if (found_reg)
                    begin
                        out_value_next = best_value_reg;
                        out_index_next = IW'((base_reg + IW'(best_r_reg)) * IW'(ew) +
                                             IW'(best_c_reg));
                    end
                    else
                    begin
                        out_value_next = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
                        out_index_next = '1;
                    end
                    state_next = mpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpa_pkg::ST_IDLE;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_r_reg      <= cur_r_next;
        cur_c_reg      <= cur_c_next;
        c0_reg         <= c0_next;
        cnt_r_reg      <= cnt_r_next;
        cnt_c_reg      <= cnt_c_next;
        base_reg       <= base_next;
        rd_r_reg       <= rd_r_next;
        rd_c_reg       <= rd_c_next;
        best_value_reg <= best_value_next;
        best_r_reg     <= best_r_next;
        best_c_reg     <= best_c_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_empty_reg  <= out_empty_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.max_value    = out_value_reg;
    assign res.max_index    = out_index_reg;
    assign res.window_empty = out_empty_reg;

endmodule

// ----- design/mpa_checker.sv -----
// port-level checks for max_pool_2d_argmax, attached by bind
// depends on max_pool_2d_argmax_defines.svh and mpa_pkg
`timescale 1ns / 1ps
`include "max_pool_2d_argmax_defines.svh"

module mpa_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_type,
    input logic res_valid,
    input logic res_ready
);

    // a result beat waits until taken
    `MPA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result beat dropped")

    // a query beat makes the block busy
    `MPA_ASSERT_NEXT(a_query_busy, req_valid && req_ready && (req_type == mpa_pkg::REQ_QUERY), !req_ready, "ready after query beat")

    // a load beat leaves the block ready
    `MPA_ASSERT_NEXT(a_load_ready, req_valid && req_ready && (req_type == mpa_pkg::REQ_LOAD), req_ready, "busy after load beat")

    // a new result only comes out of a busy period
    `MPA_ASSERT_NOW(a_res_from_busy, $rose(res_valid), $past(!req_ready), "result without query")

endmodule

bind max_pool_2d_argmax mpa_checker u_mpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .res_valid (res.valid),
    .res_ready (res.ready)
);
